FILE: hw/rtl/adgmu_pkg.sv
`default_nettype none
package adgmu_pkg;

    localparam int MAG_W = 37;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_CENTRE = 2'd2;

    localparam logic [1:0] REG_POINTS   = 2'd0;
    localparam logic [1:0] REG_MOMENTUM = 2'd1;
    localparam logic [1:0] REG_LRATE    = 2'd2;

    localparam logic [23:0] GAIN_ONE = 24'h010000;
    localparam logic [23:0] GAIN_ADD = 24'd13107;
    localparam logic [23:0] GAIN_MIN = 24'd655;
    localparam logic [23:0] GAIN_MAX = 24'hFFFFFF;
    localparam logic [15:0] GAIN_MUL = 16'd52429;

    typedef enum logic [1:0] {
        K_LOAD,
        K_UPDATE,
        K_CENTRE
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [4:0]         pt;
        logic               dm;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic [5:0]  cnt;
        logic [15:0] mom;
        logic [9:0]  lr;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (x < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/adgmu_if.sv
`default_nettype none
interface adgmu_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [4:0]         point_index;
    logic               dim_index;
    logic signed [31:0] value;

    modport source(output valid, output action, output point_index, output dim_index,
                   output value, input ready);
    modport sink(input valid, input action, input point_index, input dim_index,
                 input value, output ready);
endinterface

interface adgmu_res_if;
    logic               valid;
    logic               ready;
    logic [4:0]         out_point;
    logic               out_dim;
    logic signed [31:0] position;
    logic               last;

    modport source(output valid, output out_point, output out_dim, output position,
                   output last, input ready);
    modport sink(input valid, input out_point, input out_dim, input position,
                 input last, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/adaptive_gain_momentum_update_unit.sv
`default_nettype none
// channel   | dir | payload                                   | handshake
// i_cmd     | in  | action, point_index, dim_index, value     | valid / ready
// o_res     | out | out_point, out_dim, position, last        | valid / ready
// apb       | in  | psel, penable, pwrite, paddr, pwdata      | pready tied high
//
// load writes the position; update runs one memory read, four arithmetic steps, then writeback
// centre on n slots runs a sum sweep, a 37-step divider, then an emit sweep
// a 2-entry queue lets the input keep taking items while the back end works
// reset is synchronous; memories need no clearing pass, velocity/gain use valid bits
// a stalled output holds the back end; the front stalls only when the queue is full
module adaptive_gain_momentum_update_unit #(
    parameter int MAX_POINTS = 32,
    parameter int DIMS       = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    adgmu_cmd_if.sink   i_cmd,
    adgmu_res_if.source o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import adgmu_pkg::*;

    logic [5:0]  r_points;
    logic [15:0] r_mom;
    logic [9:0]  r_lr;
    t_cfg        cfg;
    t_cmd        q_cmd;
    logic        q_valid;
    logic        q_pop;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= 6'd32;
            r_mom    <= 16'd32768;
            r_lr     <= 10'd200;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_POINTS:   r_points <= pwdata[5:0];
                REG_MOMENTUM: r_mom    <= pwdata[15:0];
                REG_LRATE:    r_lr     <= pwdata[9:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_POINTS:   prdata = {26'd0, r_points};
            REG_MOMENTUM: prdata = {16'd0, r_mom};
            REG_LRATE:    prdata = {22'd0, r_lr};
            default:      prdata = 32'd0;
        endcase
        if (r_points == 6'd0) begin
            cfg.cnt = 6'd1;
        end else if (r_points > 6'(MAX_POINTS)) begin
            cfg.cnt = 6'(MAX_POINTS);
        end else begin
            cfg.cnt = r_points;
        end
        cfg.mom = r_mom;
        cfg.lr  = r_lr;
    end

    adgmu_front #(
        .MAX_POINTS (MAX_POINTS),
        .DIMS       (DIMS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_cmd       (q_cmd),
        .o_cmd_valid (q_valid),
        .i_cmd_pop   (q_pop)
    );

    adgmu_back #(
        .MAX_POINTS (MAX_POINTS),
        .DIMS       (DIMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .i_cfg       (cfg),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/adgmu_front.sv
`default_nettype none
module adgmu_front #(
    parameter int MAX_POINTS = 32,
    parameter int DIMS       = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    adgmu_cmd_if.sink        i_cmd,
    output adgmu_pkg::t_cmd  o_cmd,
    output logic             o_cmd_valid,
    input  logic             i_cmd_pop
);
    import adgmu_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       keep;
    logic       in_range;
    logic       push;
    logic       pop;
    t_cmd       entry;

    always_comb begin
        in_range = (6'(i_cmd.point_index) < 6'(MAX_POINTS)) &&
                   (2'(i_cmd.dim_index) < 2'(DIMS));
        entry.pt    = i_cmd.point_index;
        entry.dm    = i_cmd.dim_index;
        entry.value = i_cmd.value;
        unique case (i_cmd.action)
            ACT_LOAD: begin
                keep       = in_range;
                entry.kind = K_LOAD;
            end
            ACT_UPDATE: begin
                keep       = in_range;
                entry.kind = K_UPDATE;
            end
            ACT_CENTRE: begin
                keep       = 1'b1;
                entry.kind = K_CENTRE;
            end
            default: begin
                keep       = 1'b0;
                entry.kind = K_LOAD;
            end
        endcase
    end

    // dropped items (bad action or address) are taken and vanish here
    assign i_cmd.ready = (r_cnt != 2'd2);
    assign push        = i_cmd.valid && i_cmd.ready && keep;
    assign pop         = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= entry;
                r_wp      <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/adgmu_back.sv
`default_nettype none
module adgmu_back #(
    parameter int MAX_POINTS = 32,
    parameter int DIMS       = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  adgmu_pkg::t_cmd i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_pop,
    input  adgmu_pkg::t_cfg i_cfg,
    adgmu_res_if.source     o_res
);
    import adgmu_pkg::*;

    localparam int SLOTS = MAX_POINTS * DIMS;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_URD, S_U1, S_U2, S_U3, S_U4, S_U5,
        S_CSRD, S_CSACC, S_CDSET, S_CDIV, S_CMEAN, S_CERD, S_CEWR
    } t_state;

    logic signed [31:0] pos_mem  [SLOTS];
    logic signed [31:0] vel_mem  [SLOTS];
    logic [23:0]        gain_mem [SLOTS];
    logic [SLOTS-1:0]   r_vld;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [SW-1:0]      r_slot;
    logic signed [31:0] r_pos_q;
    logic signed [31:0] r_vel_q;
    logic [23:0]        r_gain_q;
    logic               r_vq;
    logic [23:0]        r_gain;
    logic signed [32:0] r_mom;
    logic signed [40:0] r_gp;
    logic signed [51:0] r_step;
    logic signed [31:0] r_vel;
    logic [5:0]         r_cnt;
    logic [6:0]         r_nslots;
    logic [6:0]         r_idx;
    logic signed [37:0] r_sum  [2];
    logic               r_neg  [2];
    logic [MAG_W-1:0]   r_quo  [2];
    logic [5:0]         r_rem  [2];
    logic signed [37:0] r_mean [2];
    logic [5:0]         r_dstep;
    logic               r_ov;
    logic [4:0]         r_o_pt;
    logic               r_o_dm;
    logic signed [31:0] r_o_pos;
    logic               r_o_last;

    logic               rd_en;
    logic [SW-1:0]      rd_addr;
    logic [SW-1:0]      wr_addr;
    logic               pos_we;
    logic signed [31:0] pos_wd;
    logic               out_free;
    logic [5:0]         cmd_slot6;
    logic               cdim;
    logic [4:0]         cpt;
    logic signed [31:0] vel_in;
    logic [23:0]        gain_in;
    logic               differ;
    logic [24:0]        g_add;
    logic [39:0]        g_mul_p;
    logic [23:0]        g_sel;
    logic [23:0]        g_new;
    logic signed [48:0] mom_p;
    logic signed [56:0] gp_p;
    logic signed [51:0] st_p;
    logic signed [31:0] vel_new;
    logic signed [31:0] upd_pos;
    logic signed [31:0] ctr_pos;
    logic [6:0]         rem_sh [2];
    logic               q_bit  [2];
    logic [MAG_W-1:0]   mag    [2];

    always_comb begin
        cmd_slot6 = (DIMS == 2) ? {i_cmd.pt, i_cmd.dm} : {1'b0, i_cmd.pt};
        cdim      = (DIMS == 2) ? r_idx[0] : 1'b0;
        cpt       = (DIMS == 2) ? r_idx[5:1] : r_idx[4:0];
        out_free  = !r_ov || o_res.ready;
        o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
        rd_en     = (r_state == S_URD) || (r_state == S_CSRD) || (r_state == S_CERD);
        rd_addr   = (r_state == S_URD) ? r_slot : r_idx[SW-1:0];
        wr_addr   = (r_state == S_CEWR) ? r_idx[SW-1:0] : r_slot;

        // gain adaptation
        vel_in  = r_vq ? r_vel_q : 32'sd0;
        gain_in = r_vq ? r_gain_q : GAIN_ONE;
        differ  = (r_cmd.value[31] != vel_in[31]) ||
                  ((r_cmd.value == 32'sd0) != (vel_in == 32'sd0));
        g_add   = {1'b0, gain_in} + {1'b0, GAIN_ADD};
        g_mul_p = 40'(gain_in) * 40'(GAIN_MUL);
        if (differ) begin
            g_sel = g_add[24] ? GAIN_MAX : g_add[23:0];
        end else begin
            g_sel = g_mul_p[39:16];
        end
        g_new = (g_sel < GAIN_MIN) ? GAIN_MIN : g_sel;

        mom_p   = $signed({1'b0, i_cfg.mom}) * vel_in;
        gp_p    = $signed({1'b0, r_gain}) * r_cmd.value;
        st_p    = $signed({1'b0, i_cfg.lr}) * r_gp;
        vel_new = sat32(64'(r_mom) - 64'(r_step));
        upd_pos = sat32(64'(r_pos_q) + 64'(r_vel));
        ctr_pos = sat32(64'(r_pos_q) - 64'(r_mean[cdim]));

        pos_we = ((r_state == S_U5) || (r_state == S_CEWR)) && out_free;
        pos_wd = (r_state == S_U5) ? upd_pos : ctr_pos;
        if (r_state == S_LOAD) begin
            pos_we = 1'b1;
            pos_wd = r_cmd.value;
        end

        // one quotient bit per lane per cycle
        for (int d = 0; d < 2; d++) begin
            rem_sh[d] = {r_rem[d], r_quo[d][MAG_W-1]};
            q_bit[d]  = (rem_sh[d] >= {1'b0, r_cnt});
            mag[d]    = r_sum[d][37] ? MAG_W'(-r_sum[d]) : MAG_W'(r_sum[d]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_pos_q  <= pos_mem[rd_addr];
            r_vel_q  <= vel_mem[rd_addr];
            r_gain_q <= gain_mem[rd_addr];
            r_vq     <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[wr_addr] <= pos_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_U4) begin
            vel_mem[r_slot]  <= vel_new;
            gain_mem[r_slot] <= r_gain;
        end
    end

    // cleared valid bit reads as zero velocity and unit gain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (r_state == S_LOAD) begin
            r_vld[r_slot] <= 1'b0;
        end else if (r_state == S_U4) begin
            r_vld[r_slot] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd    <= i_cmd;
                        r_slot   <= cmd_slot6[SW-1:0];
                        r_cnt    <= i_cfg.cnt;
                        r_nslots <= 7'(i_cfg.cnt) * 7'(DIMS);
                        r_idx    <= 7'd0;
                        r_sum[0] <= 38'sd0;
                        r_sum[1] <= 38'sd0;
                        unique case (i_cmd.kind)
                            K_LOAD:   r_state <= S_LOAD;
                            K_UPDATE: r_state <= S_URD;
                            K_CENTRE: r_state <= S_CSRD;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_LOAD: r_state <= S_IDLE;
                S_URD:  r_state <= S_U1;
                S_U1: begin
                    r_gain  <= g_new;
                    r_mom   <= mom_p[48:16];
                    r_state <= S_U2;
                end
                S_U2: begin
                    r_gp    <= gp_p[56:16];
                    r_state <= S_U3;
                end
                S_U3: begin
                    r_step  <= st_p;
                    r_state <= S_U4;
                end
                S_U4: begin
                    r_vel   <= vel_new;
                    r_state <= S_U5;
                end
                S_U5: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_o_pt   <= r_cmd.pt;
                        r_o_dm   <= r_cmd.dm;
                        r_o_pos  <= upd_pos;
                        r_o_last <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_CSRD: r_state <= S_CSACC;
                S_CSACC: begin
                    r_sum[cdim] <= r_sum[cdim] + 38'(r_pos_q);
                    if (r_idx == r_nslots - 7'd1) begin
                        r_state <= S_CDSET;
                    end else begin
                        r_idx   <= r_idx + 7'd1;
                        r_state <= S_CSRD;
                    end
                end
                S_CDSET: begin
                    for (int d = 0; d < 2; d++) begin
                        r_neg[d] <= r_sum[d][37];
                        r_quo[d] <= mag[d];
                        r_rem[d] <= 6'd0;
                    end
                    r_dstep <= 6'd0;
                    r_state <= S_CDIV;
                end
                S_CDIV: begin
                    for (int d = 0; d < 2; d++) begin
                        r_rem[d] <= q_bit[d] ? 6'(rem_sh[d] - {1'b0, r_cnt}) : 6'(rem_sh[d]);
                        r_quo[d] <= {r_quo[d][MAG_W-2:0], q_bit[d]};
                    end
                    r_dstep <= r_dstep + 6'd1;
                    if (r_dstep == 6'(MAG_W - 1)) begin
                        r_state <= S_CMEAN;
                    end
                end
                S_CMEAN: begin
                    for (int d = 0; d < 2; d++) begin
                        r_mean[d] <= r_neg[d] ? -$signed({1'b0, r_quo[d]})
                                              : $signed({1'b0, r_quo[d]});
                    end
                    r_idx   <= 7'd0;
                    r_state <= S_CERD;
                end
                S_CERD: r_state <= S_CEWR;
                S_CEWR: begin
                    if (out_free) begin
                        r_ov     <= 1'b1;
                        r_o_pt   <= cpt;
                        r_o_dm   <= cdim;
                        r_o_pos  <= ctr_pos;
                        r_o_last <= (r_idx == r_nslots - 7'd1);
                        if (r_idx == r_nslots - 7'd1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 7'd1;
                            r_state <= S_CERD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.out_point = r_o_pt;
    assign o_res.out_dim   = r_o_dm;
    assign o_res.position  = r_o_pos;
    assign o_res.last      = r_o_last;

    a_gain_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_U4) |-> (r_gain >= GAIN_MIN))
        else $error("gain below floor at write");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CSRD) || (r_state == S_CERD)) |-> (r_idx < r_nslots))
        else $error("centre index past point count");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CDIV) |-> ((r_cnt != 6'd0) && (r_cnt <= 6'(MAX_POINTS))))
        else $error("divisor out of range");

endmodule
`default_nettype wire

FILE: tb/sv/tb_adaptive_gain_momentum_update_unit.sv
`timescale 1ns / 100ps
module tb_adaptive_gain_momentum_update_unit;
    import adgmu_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic [4:0]         pt;
        logic               dm;
        logic signed [31:0] pos;
        logic               last;
    } t_position;

    typedef struct {
        logic [1:0]         act;
        logic [4:0]         pt;
        logic               dm;
        logic signed [31:0] val;
        bit                 typed;
        logic signed [31:0] pos;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    adgmu_cmd_if cmd ();
    adgmu_res_if res ();

    adaptive_gain_momentum_update_unit DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd.sink),
        .o_res  (res.source),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    int signed   pos_mem [64];
    int signed   vel_mem [64];
    logic [23:0] gain_mem[64];
    logic [5:0]  cfg_cnt = 6'd32;
    logic [15:0] cfg_mom = 16'd32768;
    logic [9:0]  cfg_lr  = 10'd200;

    t_position pending_positions[$];
    int        errors = 0;
    bit        calm = 1'b0;

    function automatic int signed clip32(longint x);
        if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'sh8000_0000;
        return int'(x);
    endfunction

    function automatic int sign3(longint x);
        return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
    endfunction

    function automatic void predict_step(logic [1:0] act, logic [4:0] pt, logic dm,
                                         logic signed [31:0] val);
        int         slot;
        logic [31:0] g;
        longint     mterm;
        longint     stp;
        longint     sums[2];
        longint     mean[2];
        int         n;
        t_position  r;
        slot = {pt, dm};
        if (act == ACT_LOAD) begin
            pos_mem[slot] = val;
            vel_mem[slot] = 0;
            gain_mem[slot] = GAIN_ONE;
        end else if (act == ACT_UPDATE) begin
            g = gain_mem[slot];
            if (sign3(val) != sign3(vel_mem[slot])) begin
                g = g + GAIN_ADD;
                if (g > GAIN_MAX) g = GAIN_MAX;
            end else begin
                g = (longint'(g) * GAIN_MUL) >> 16;
            end
            if (g < GAIN_MIN) g = GAIN_MIN;
            gain_mem[slot] = g[23:0];
            mterm = (longint'(cfg_mom) * longint'(vel_mem[slot])) >>> 16;
            stp = longint'(cfg_lr) * ((longint'(g) * longint'(val)) >>> 16);
            vel_mem[slot] = clip32(mterm - stp);
            pos_mem[slot] = clip32(longint'(pos_mem[slot]) + vel_mem[slot]);
            r.pt = pt; r.dm = dm; r.pos = pos_mem[slot]; r.last = 1'b0;
            pending_positions.push_back(r);
        end else if (act == ACT_CENTRE) begin
            n = (cfg_cnt < 1) ? 1 : ((cfg_cnt > 32) ? 32 : cfg_cnt);
            for (int d = 0; d < 2; d++) begin
                sums[d] = 0;
                for (int p = 0; p < n; p++) sums[d] += pos_mem[p * 2 + d];
                mean[d] = sums[d] / longint'(n);
            end
            for (int p = 0; p < n; p++) begin
                for (int d = 0; d < 2; d++) begin
                    pos_mem[p * 2 + d] = clip32(longint'(pos_mem[p * 2 + d]) - mean[d]);
                    r.pt = p[4:0]; r.dm = d[0]; r.pos = pos_mem[p * 2 + d];
                    r.last = (p == n - 1 && d == 1);
                    pending_positions.push_back(r);
                end
            end
        end
    endfunction

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_POINTS:   cfg_cnt = data[5:0];
            REG_MOMENTUM: cfg_mom = data[15:0];
            REG_LRATE:    cfg_lr  = data[9:0];
            default: ;
        endcase
    endtask

    // typed: expected position taken from the row instead of the predictor
    task automatic send_item(logic [1:0] act, logic [4:0] pt, logic dm,
                             logic signed [31:0] val, bit typed, logic signed [31:0] pos);
        int gap;
        t_position r;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd.valid <= 1'b1;
        cmd.action <= act; cmd.point_index <= pt; cmd.dim_index <= dm; cmd.value <= val;
        do @(posedge i_clk); while (!cmd.ready);
        predict_step(act, pt, dm, val);
        if (typed) begin
            r = pending_positions.pop_back();
            r.pos = pos;
            pending_positions.push_back(r);
        end
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return $signed($urandom_range(0, 200000)) - 32'sd100000;
            default: return $urandom;
        endcase
    endfunction

    // result side: random stall per item, compare against oldest expectation
    initial begin : result_check
        int stall;
        t_position e;
        res.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res.ready <= 1'b1;
            do @(posedge i_clk); while (!(res.valid && res.ready));
            if (pending_positions.size() == 0) begin
                $display("%0t: unexpected position pt=%0d dm=%0d pos=%h last=%0d", $time,
                         res.out_point, res.out_dim, res.position, res.last);
                errors++;
            end else begin
                e = pending_positions.pop_front();
                if (res.out_point !== e.pt || res.out_dim !== e.dm ||
                    res.position !== e.pos || res.last !== e.last) begin
                    $display("%0t: expected pt=%0d dm=%0d pos=%h last=%0d, got pt=%0d dm=%0d pos=%h last=%0d",
                             $time, e.pt, e.dm, e.pos, e.last,
                             res.out_point, res.out_dim, res.position, res.last);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        t_row rows[$];
        int act_pick;
        logic [5:0]  cnt_set [6] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd17, 6'd5};
        logic [15:0] mom_set [6] = '{16'd0, 16'hFFFF, 16'd32768, 16'd1, 16'd60000, 16'd12345};
        logic [9:0]  lr_set  [6] = '{10'd0, 10'd1023, 10'd200, 10'd1, 10'd37, 10'd500};
        cmd.valid = 1'b0; cmd.action = ACT_LOAD; cmd.point_index = '0;
        cmd.dim_index = 1'b0; cmd.value = '0;
        for (int i = 0; i < 64; i++) begin
            pos_mem[i] = 0; vel_mem[i] = 0; gain_mem[i] = GAIN_ONE;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_write(REG_POINTS, 32'd2);
        apb_write(REG_MOMENTUM, 32'd32768);
        apb_write(REG_LRATE, 32'd200);

        rows = '{
            '{ACT_LOAD,   5'd0,  1'b0, 32'sh7FFF_FFFF, 1'b0, 32'sd0},
            '{ACT_UPDATE, 5'd0,  1'b0, 32'sd0,         1'b1, 32'sh7FFF_FFFF},
            '{ACT_LOAD,   5'd0,  1'b1, 32'sh8000_0000, 1'b0, 32'sd0},
            '{ACT_UPDATE, 5'd0,  1'b1, 32'sd1,         1'b1, 32'sh8000_0000},
            '{ACT_LOAD,   5'd1,  1'b0, 32'sd0,         1'b0, 32'sd0},
            '{ACT_LOAD,   5'd1,  1'b1, -32'sd1,        1'b0, 32'sd0},
            '{ACT_NONE,   5'd31, 1'b1, 32'sh1234_5678, 1'b0, 32'sd0},
            '{ACT_UPDATE, 5'd1,  1'b0, 32'sh7FFF_FFFF, 1'b0, 32'sd0},
            '{ACT_UPDATE, 5'd1,  1'b1, 32'sh8000_0000, 1'b0, 32'sd0},
            '{ACT_UPDATE, 5'd0,  1'b0, 32'shFFFF_0000, 1'b0, 32'sd0},
            '{ACT_UPDATE, 5'd1,  1'b0, 32'sd70000,     1'b0, 32'sd0},
            '{ACT_CENTRE, 5'd0,  1'b0, 32'sd0,         1'b0, 32'sd0},
            '{ACT_UPDATE, 5'd1,  1'b0, 32'sd0,         1'b0, 32'sd0},
            '{ACT_LOAD,   5'd31, 1'b1, 32'sh0001_0000, 1'b0, 32'sd0},
            '{ACT_UPDATE, 5'd31, 1'b1, 32'sh8000_0000, 1'b0, 32'sd0},
            '{ACT_UPDATE, 5'd31, 1'b1, -32'sd3,        1'b0, 32'sd0},
            '{ACT_CENTRE, 5'd0,  1'b0, 32'sd0,         1'b0, 32'sd0}
        };
        foreach (rows[i])
            send_item(rows[i].act, rows[i].pt, rows[i].dm, rows[i].val,
                      rows[i].typed, rows[i].pos);
        drain();

        // every position gets a value so centre may cover all points
        for (int s = 0; s < 64; s++)
            send_item(ACT_LOAD, s[5:1], s[0], rand_value(), 1'b0, 32'sd0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            apb_write(REG_POINTS, 32'(cnt_set[ph]));
            apb_write(REG_MOMENTUM, 32'(mom_set[ph]));
            apb_write(REG_LRATE, 32'(lr_set[ph]));
            calm = (ph == 2);
            for (int k = 0; k < 45; k++) begin
                act_pick = $urandom_range(0, 99);
                if (act_pick < 12)
                    send_item(ACT_LOAD, 5'($urandom), 1'($urandom), rand_value(),
                              1'b0, 32'sd0);
                else if (act_pick < 88)
                    send_item(ACT_UPDATE, 5'($urandom), 1'($urandom), rand_value(),
                              1'b0, 32'sd0);
                else if (act_pick < 95)
                    send_item(ACT_CENTRE, 5'($urandom), 1'($urandom), $urandom,
                              1'b0, 32'sd0);
                else
                    send_item(ACT_NONE, 5'($urandom), 1'($urandom), $urandom,
                              1'b0, 32'sd0);
            end
            drain();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #30ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
